>>> rtl/rot_pkg.sv
`timescale 1ns / 1ps
// rot_pkg: shared constants, codes, types and the quarter-wave sine generator
// for the point rotation block. No dependencies.
package rot_pkg;

  localparam int PHASE_BITS_DEF = 10;
  localparam int COORD_BITS_DEF = 16;

  // Q1.14 trig values, Q3.14 coefficients
  localparam int TRIG_W    = 16;
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 14;
  localparam int ONE_Q14   = 1 << FRAC_BITS;

  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [MODE_W-1:0] {
    MODE_X   = 2'd0,
    MODE_Y   = 2'd1,
    MODE_Z   = 2'd2,
    MODE_YXZ = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_ANGLE_X  = 3'd1,
    REG_ANGLE_Y  = 3'd2,
    REG_ANGLE_Z  = 3'd3,
    REG_CENTER_X = 3'd4,
    REG_CENTER_Y = 3'd5,
    REG_CENTER_Z = 3'd6
  } cfg_reg_e;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [2:0][2:0] coef_mat_t;

  typedef struct packed {
    logic s1_vld;
    logic s2_vld;
    logic s3_vld;
  } pipe_stat_t;

  // Quarter-wave sine entry k of 2^(pb-2) steps, Q14, from a truncated
  // Taylor series in Q30. Evaluated at elaboration only.
  function automatic logic [TRIG_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned pb);
    longint unsigned kk;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    longint          r;
    int              n;
    kk  = k;
    x   = (kk * HALF_PI_Q30 + ((64'd1 << (pb - 2)) >> 1)) >> (pb - 2);
    x2  = (x * x) >> 30;
    t   = x;
    sum = longint'(x);
    for (n = 1; n <= 7; n++) begin
      t = (t * x2) >> 30;
      case (n)
        1:       t = t / 6;
        2:       t = t / 20;
        3:       t = t / 42;
        4:       t = t / 72;
        5:       t = t / 110;
        6:       t = t / 156;
        default: t = t / 210;
      endcase
      if (n[0]) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    r = (sum > 0) ? ((sum + 32768) >>> 16) : 0;
    if (r > ONE_Q14) begin
      r = ONE_Q14;
    end
    return TRIG_W'(r);
  endfunction

endpackage

>>> rtl/rot_in_if.sv
`timescale 1ns / 1ps
// rot_in_if: input point channel, valid/ready plus one point word.
// Depends on rot_pkg for the default coordinate width.
interface rot_in_if #(
  parameter int COORD_BITS = rot_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic signed [COORD_BITS-1:0] in_z;

  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

>>> rtl/rot_out_if.sv
`timescale 1ns / 1ps
// rot_out_if: result channel, valid/ready plus one rotated point word.
// Depends on rot_pkg for the default coordinate width.
interface rot_out_if #(
  parameter int COORD_BITS = rot_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic signed [COORD_BITS-1:0] out_z;
  logic                         clipped;

  modport source (output valid, out_x, out_y, out_z, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

>>> rtl/rot_coef.sv
`timescale 1ns / 1ps
// rot_coef: free-running coefficient pipeline, sine ROM -> pair products ->
// triple products -> round and mode select. Depends on rot_pkg.
module rot_coef #(
  parameter int PHASE_BITS = rot_pkg::PHASE_BITS_DEF
) (
  input  logic                      clk,
  input  rot_pkg::mode_e            mode,
  input  logic [PHASE_BITS-1:0]     angle_x,
  input  logic [PHASE_BITS-1:0]     angle_y,
  input  logic [PHASE_BITS-1:0]     angle_z,
  output rot_pkg::coef_mat_t        coef_r
);
  import rot_pkg::*;

  localparam int QTR   = 1 << (PHASE_BITS - 2);
  localparam int IDX_W = PHASE_BITS - 1;
  localparam int PW    = 2 * TRIG_W;
  localparam int PSW   = PW + 1;
  localparam int TW    = 3 * TRIG_W;
  localparam int SW    = TW + 2;

  localparam int SX = 0, CX = 1, SY = 2, CY = 3, SZ = 4, CZ = 5;
  localparam int P_CYCX = 0, P_CYSX = 1, P_SYSZ = 2, P_SYCZ = 3, P_CXCZ = 4;
  localparam int P_CXSZ = 5, P_SYCX = 6, P_SYSX = 7, P_CYSZ = 8, P_CYCZ = 9;
  localparam int T_CYSXCZ = 0, T_CYSXSZ = 1, T_SYSXCZ = 2, T_SYSXSZ = 3;

  localparam logic signed [PSW-1:0] RND_P = PSW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0]  RND_T = SW'(1) <<< (2 * FRAC_BITS - 1);

  logic [TRIG_W-1:0]        qsin_rom [QTR+1];
  logic [PHASE_BITS-1:0]    phase    [6];
  logic signed [TRIG_W-1:0] trig_nxt [6];
  logic signed [TRIG_W-1:0] trig_a_r [6];
  logic signed [TRIG_W-1:0] trig_b_r [6];
  logic signed [TRIG_W-1:0] trig_c_r [6];
  logic signed [PW-1:0]     pair_b_r [10];
  logic signed [PW-1:0]     pair_c_r [10];
  logic signed [TW-1:0]     tri_c_r  [4];
  logic signed [SW-1:0]     s01, s02, s21, s22;
  coef_mat_t                coef_nxt;

  for (genvar k = 0; k <= QTR; k++) begin : g_rom
    assign qsin_rom[k] = quarter_sine(k, PHASE_BITS);
  end

  // Stage A: phase -> signed sine/cosine through quadrant folding
  always_comb begin
    logic [1:0]            quad;
    logic [PHASE_BITS-3:0] rem;
    logic [IDX_W-1:0]      idx;
    logic [TRIG_W-1:0]     mag;
    phase[SX] = angle_x;
    phase[CX] = angle_x + PHASE_BITS'(QTR);
    phase[SY] = angle_y;
    phase[CY] = angle_y + PHASE_BITS'(QTR);
    phase[SZ] = angle_z;
    phase[CZ] = angle_z + PHASE_BITS'(QTR);
    for (int i = 0; i < 6; i++) begin
      quad = phase[i][PHASE_BITS-1 -: 2];
      rem  = phase[i][PHASE_BITS-3:0];
      idx  = quad[0] ? (IDX_W'(QTR) - IDX_W'(rem)) : IDX_W'(rem);
      mag  = qsin_rom[idx];
      trig_nxt[i] = quad[1] ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk) begin
    trig_a_r <= trig_nxt;
    // Stage B: pairwise products
    trig_b_r         <= trig_a_r;
    pair_b_r[P_CYCX] <= trig_a_r[CY] * trig_a_r[CX];
    pair_b_r[P_CYSX] <= trig_a_r[CY] * trig_a_r[SX];
    pair_b_r[P_SYSZ] <= trig_a_r[SY] * trig_a_r[SZ];
    pair_b_r[P_SYCZ] <= trig_a_r[SY] * trig_a_r[CZ];
    pair_b_r[P_CXCZ] <= trig_a_r[CX] * trig_a_r[CZ];
    pair_b_r[P_CXSZ] <= trig_a_r[CX] * trig_a_r[SZ];
    pair_b_r[P_SYCX] <= trig_a_r[SY] * trig_a_r[CX];
    pair_b_r[P_SYSX] <= trig_a_r[SY] * trig_a_r[SX];
    pair_b_r[P_CYSZ] <= trig_a_r[CY] * trig_a_r[SZ];
    pair_b_r[P_CYCZ] <= trig_a_r[CY] * trig_a_r[CZ];
    // Stage C: triple products
    trig_c_r           <= trig_b_r;
    pair_c_r           <= pair_b_r;
    tri_c_r[T_CYSXCZ]  <= pair_b_r[P_CYSX] * trig_b_r[CZ];
    tri_c_r[T_CYSXSZ]  <= pair_b_r[P_CYSX] * trig_b_r[SZ];
    tri_c_r[T_SYSXCZ]  <= pair_b_r[P_SYSX] * trig_b_r[CZ];
    tri_c_r[T_SYSXSZ]  <= pair_b_r[P_SYSX] * trig_b_r[SZ];
    // Stage D
    coef_r <= coef_nxt;
  end

  // Stage D: composite terms in Q42, rounded once to Q14
  assign s01 = SW'(tri_c_r[T_CYSXCZ]) + (SW'(pair_c_r[P_SYSZ]) <<< FRAC_BITS);
  assign s02 = SW'(tri_c_r[T_CYSXSZ]) - (SW'(pair_c_r[P_SYCZ]) <<< FRAC_BITS);
  assign s21 = SW'(tri_c_r[T_SYSXCZ]) - (SW'(pair_c_r[P_CYSZ]) <<< FRAC_BITS);
  assign s22 = SW'(tri_c_r[T_SYSXSZ]) + (SW'(pair_c_r[P_CYCZ]) <<< FRAC_BITS);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef_nxt[i][j] = (i == j) ? COEF_W'(ONE_Q14) : '0;
      end
    end
    case (mode)
      MODE_X: begin
        coef_nxt[1][1] = COEF_W'(trig_c_r[CX]);
        coef_nxt[1][2] = COEF_W'(trig_c_r[SX]);
        coef_nxt[2][1] = -COEF_W'(trig_c_r[SX]);
        coef_nxt[2][2] = COEF_W'(trig_c_r[CX]);
      end
      MODE_Y: begin
        coef_nxt[0][0] = COEF_W'(trig_c_r[CY]);
        coef_nxt[0][2] = -COEF_W'(trig_c_r[SY]);
        coef_nxt[2][0] = COEF_W'(trig_c_r[SY]);
        coef_nxt[2][2] = COEF_W'(trig_c_r[CY]);
      end
      MODE_Z: begin
        coef_nxt[0][0] = COEF_W'(trig_c_r[CZ]);
        coef_nxt[0][1] = -COEF_W'(trig_c_r[SZ]);
        coef_nxt[1][0] = COEF_W'(trig_c_r[SZ]);
        coef_nxt[1][1] = COEF_W'(trig_c_r[CZ]);
      end
      MODE_YXZ: begin
        coef_nxt[0][0] = COEF_W'((PSW'(pair_c_r[P_CYCX]) + RND_P) >>> FRAC_BITS);
        coef_nxt[0][1] = COEF_W'((s01 + RND_T) >>> (2 * FRAC_BITS));
        coef_nxt[0][2] = COEF_W'((s02 + RND_T) >>> (2 * FRAC_BITS));
        coef_nxt[1][0] = -COEF_W'(trig_c_r[SX]);
        coef_nxt[1][1] = COEF_W'((PSW'(pair_c_r[P_CXCZ]) + RND_P) >>> FRAC_BITS);
        coef_nxt[1][2] = COEF_W'((PSW'(pair_c_r[P_CXSZ]) + RND_P) >>> FRAC_BITS);
        coef_nxt[2][0] = COEF_W'((PSW'(pair_c_r[P_SYCX]) + RND_P) >>> FRAC_BITS);
        coef_nxt[2][1] = COEF_W'((s21 + RND_T) >>> (2 * FRAC_BITS));
        coef_nxt[2][2] = COEF_W'((s22 + RND_T) >>> (2 * FRAC_BITS));
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/rot_dp.sv
`timescale 1ns / 1ps
// rot_dp: point pipeline, offset -> matrix products -> row sum and round ->
// recenter, saturate and output register. Depends on rot_pkg.
module rot_dp #(
  parameter int COORD_BITS = rot_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_pt  [3],
  input  logic signed [COORD_BITS-1:0] center [3],
  input  rot_pkg::coef_mat_t           coef,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pt [3],
  output logic                         out_clip,
  output rot_pkg::pipe_stat_t          stat
);
  import rot_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int PRW = COEF_W + DW;
  localparam int SMW = PRW + 2;
  localparam int RW  = SMW - FRAC_BITS;
  localparam int VW  = RW + 1;

  localparam logic signed [SMW-1:0] RND = SMW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [VW-1:0]  HI  = VW'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [VW-1:0]  LO  = -HI - VW'(1);

  logic                         s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic                         adv1, adv2, adv3, adv4;
  logic signed [DW-1:0]         d_r    [3];
  logic signed [PRW-1:0]        prod_r [3][3];
  logic signed [RW-1:0]         rnd_r  [3];
  logic signed [SMW-1:0]        row_sum [3];
  logic signed [VW-1:0]         recent [3];
  logic signed [COORD_BITS-1:0] sat_val [3];
  logic [2:0]                   sat_hit;
  logic signed [COORD_BITS-1:0] out_pt_r [3];
  logic                         clip_r;

  // advance a stage when it is empty or its successor moves
  assign adv4     = !out_vld_r || out_ready;
  assign adv3     = !s3_vld_r || adv4;
  assign adv2     = !s2_vld_r || adv3;
  assign adv1     = !s1_vld_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv1) s1_vld_r  <= in_valid;
      if (adv2) s2_vld_r  <= s1_vld_r;
      if (adv3) s3_vld_r  <= s2_vld_r;
      if (adv4) out_vld_r <= s3_vld_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      row_sum[i] = SMW'(prod_r[i][0]) + SMW'(prod_r[i][1]) + SMW'(prod_r[i][2]) + RND;
      recent[i]  = VW'(rnd_r[i]) + VW'(center[i]);
      if (recent[i] > HI) begin
        sat_val[i] = COORD_BITS'(HI);
        sat_hit[i] = 1'b1;
      end else if (recent[i] < LO) begin
        sat_val[i] = COORD_BITS'(LO);
        sat_hit[i] = 1'b1;
      end else begin
        sat_val[i] = COORD_BITS'(recent[i]);
        sat_hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= DW'(in_pt[i]) - DW'(center[i]);
      end
    end
    if (adv2) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(coef[i][j]) * d_r[j];
        end
      end
    end
    if (adv3) begin
      for (int i = 0; i < 3; i++) begin
        rnd_r[i] <= RW'(row_sum[i] >>> FRAC_BITS);
      end
    end
    if (adv4) begin
      out_pt_r <= sat_val;
      clip_r   <= |sat_hit;
    end
  end

  assign out_valid = out_vld_r;
  assign out_pt    = out_pt_r;
  assign out_clip  = clip_r;

  always_comb begin
    stat.s1_vld = s1_vld_r;
    stat.s2_vld = s2_vld_r;
    stat.s3_vld = s3_vld_r;
  end

endmodule

>>> rtl/point_rotate_about_center.sv
`timescale 1ns / 1ps
// point_rotate_about_center: top level, configuration registers, coefficient
// settle gate and assertions. Depends on rot_pkg, rot_in_if, rot_out_if,
// rot_coef and rot_dp.
//
//   channel   dir   handshake          word
//   in_ch     in    valid / ready      in_x, in_y, in_z   (signed Q8.8)
//   out_ch    out   valid / ready      out_x, out_y, out_z, clipped
//   cfg_*     in    cfg_we (no wait)   cfg_idx, cfg_wdata
//
// One point word per clock sustained while out_ch is ready and no cfg write is
// settling. An accepted word passes the offset, products, row sum and output
// registers to out_ch. The coefficient matrix comes from a free-running 4-stage
// unit (sine ROM, pair products, triple products, round and mode select); after
// reset and after any cfg write the input is held off while it refills. Reset
// is synchronous, active low, and clears the valid bits and config registers.
// Back-pressure on out_ch ripples stage by stage; a full pipe holds in_ch off.
module point_rotate_about_center #(
  parameter int PHASE_BITS = rot_pkg::PHASE_BITS_DEF,
  parameter int COORD_BITS = rot_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rot_in_if.sink                            in_ch,
  rot_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [rot_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [((COORD_BITS > PHASE_BITS) ? COORD_BITS : PHASE_BITS)-1:0] cfg_wdata
);
  import rot_pkg::*;

  // settle counter load value, applied after reset and after every config write
  localparam int COEF_SETTLE = 3;
  localparam int SETTLE_W    = $clog2(COEF_SETTLE + 1);

  localparam logic signed [COORD_BITS-1:0] CRD_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] CRD_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  mode_e                        mode_r;
  logic [PHASE_BITS-1:0]        ang_r [3];
  logic signed [COORD_BITS-1:0] ctr_r [3];
  logic [SETTLE_W-1:0]          settle_r;
  logic                         coef_ok;
  coef_mat_t                    coef;
  logic                         dp_ready;
  logic signed [COORD_BITS-1:0] in_pt  [3];
  logic signed [COORD_BITS-1:0] out_pt [3];
  pipe_stat_t                   stat;

  // Config writes: drop bits above each register's width, ignore bad indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_YXZ;
      for (int i = 0; i < 3; i++) begin
        ang_r[i] <= '0;
        ctr_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_idx))
        REG_MODE:     mode_r   <= mode_e'(cfg_wdata[MODE_W-1:0]);
        REG_ANGLE_X:  ang_r[0] <= cfg_wdata[PHASE_BITS-1:0];
        REG_ANGLE_Y:  ang_r[1] <= cfg_wdata[PHASE_BITS-1:0];
        REG_ANGLE_Z:  ang_r[2] <= cfg_wdata[PHASE_BITS-1:0];
        REG_CENTER_X: ctr_r[0] <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Y: ctr_r[1] <= cfg_wdata[COORD_BITS-1:0];
        REG_CENTER_Z: ctr_r[2] <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input off until the coefficient unit has caught up
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      settle_r <= SETTLE_W'(COEF_SETTLE);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - SETTLE_W'(1);
    end
  end

  assign coef_ok = (settle_r == '0);

  rot_coef #(
    .PHASE_BITS (PHASE_BITS)
  ) u_coef (
    .clk     (clk),
    .mode    (mode_r),
    .angle_x (ang_r[0]),
    .angle_y (ang_r[1]),
    .angle_z (ang_r[2]),
    .coef_r  (coef)
  );

  assign in_pt[0] = in_ch.in_x;
  assign in_pt[1] = in_ch.in_y;
  assign in_pt[2] = in_ch.in_z;

  rot_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid && coef_ok),
    .in_ready  (dp_ready),
    .in_pt     (in_pt),
    .center    (ctr_r),
    .coef      (coef),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pt    (out_pt),
    .out_clip  (out_ch.clipped),
    .stat      (stat)
  );

  assign in_ch.ready  = dp_ready && coef_ok;
  assign out_ch.out_x = out_pt[0];
  assign out_ch.out_y = out_pt[1];
  assign out_ch.out_z = out_pt[2];

  // A config write must keep the next word out while coefficients refill
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !(in_ch.valid && in_ch.ready))
    else $error("word accepted right after a config write");

  // An accepted word lands in the first stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> stat.s1_vld)
    else $error("accepted word missing from first stage");

  // A full, stalled pipe must not take another word
  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready && stat.s1_vld && stat.s2_vld && stat.s3_vld)
    |-> !in_ch.ready)
    else $error("word accepted into a full pipe");

  // A clipped result has at least one coordinate at a bound
  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clipped) |->
    (out_ch.out_x == CRD_HI || out_ch.out_x == CRD_LO ||
     out_ch.out_y == CRD_HI || out_ch.out_y == CRD_LO ||
     out_ch.out_z == CRD_HI || out_ch.out_z == CRD_LO))
    else $error("clipped set with no coordinate at a bound");

endmodule
